[src/json_stream_validator_assert.svh]
// Assertion helpers for the JSON validator. Both expect clk and rst in scope.
`ifndef JSON_STREAM_VALIDATOR_ASSERT_SVH
`define JSON_STREAM_VALIDATOR_ASSERT_SVH

// Same-cycle implication.
`define JSV_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("json_stream_validator: same-cycle check failed");

// Next-cycle implication.
`define JSV_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("json_stream_validator: next-cycle check failed");

`endif

[src/jsv_pkg.sv]
package jsv_pkg;

  typedef enum logic [3:0] {
    ST_PENDING      = 4'd0,
    ST_VALID        = 4'd1,
    ST_BAD_UNICODE  = 4'd2,
    ST_BAD_ESCAPE   = 4'd3,
    ST_CTRL_CHAR    = 4'd4,
    ST_TOO_DEEP     = 4'd5,
    ST_BAD_BRACE    = 4'd6,
    ST_BAD_BRACKET  = 4'd7,
    ST_COMMA_BRACE  = 4'd8,
    ST_COMMA_BRACKET= 4'd9,
    ST_BAD_LITERAL  = 4'd10,
    ST_BAD_CHAR     = 4'd11,
    ST_UNTERM_STR   = 4'd12,
    ST_UNCLOSED     = 4'd13
  } status_t;

  typedef enum logic [1:0] {
    LIT_NONE  = 2'd0,
    LIT_TRUE  = 2'd1,
    LIT_FALSE = 2'd2,
    LIT_NULL  = 2'd3
  } lit_t;

  localparam logic [7:0] DEPTH_LIMIT_RESET = 8'd128;
  localparam logic [7:0] CTRL_LIMIT        = 8'h20;

  // Expected byte of a literal at a given position.
  function automatic logic [7:0] lit_char(input lit_t kind, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    case (kind)
      LIT_TRUE: begin
        case (pos)
          3'd0:    ch = "t";
          3'd1:    ch = "r";
          3'd2:    ch = "u";
          3'd3:    ch = "e";
          default: ch = 8'h00;
        endcase
      end
      LIT_FALSE: begin
        case (pos)
          3'd0:    ch = "f";
          3'd1:    ch = "a";
          3'd2:    ch = "l";
          3'd3:    ch = "s";
          3'd4:    ch = "e";
          default: ch = 8'h00;
        endcase
      end
      LIT_NULL: begin
        case (pos)
          3'd0:    ch = "n";
          3'd1:    ch = "u";
          3'd2:    ch = "l";
          3'd3:    ch = "l";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] lit_len(input lit_t kind);
    logic [2:0] len;
    case (kind)
      LIT_TRUE:  len = 3'd4;
      LIT_FALSE: len = 3'd5;
      LIT_NULL:  len = 3'd4;
      default:   len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic is_num_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || c == "." || c == "e" || c == "E" ||
           c == "+" || c == "-";
  endfunction

endpackage

[src/json_stream_validator.sv]
// Channel   | dir | tdata                          | tlast     | tuser
// ----------+-----+--------------------------------+-----------+------
// s_*       | in  | [7:0] data_byte                | is_last   | -
// m_*       | out | [3:0] status, [35:4] err. off. | doc_done  | -
// cfg_*     | in  | cfg_wdata = depth_limit        | -         | -
//
// A byte is taken each cycle s_tready is high; its status is on m_* the cycle after.
// All parser state, including the nesting stack, updates in the accepting cycle.
// The stack kind bits sit in a small memory read one level below the top.
// rst is synchronous; it clears the parser and sets depth_limit to 128.
// s_tready stays high while the output register is empty or being drained.
`include "json_stream_validator_assert.svh"

module json_stream_validator #(
  parameter int MAX_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [3:0] status, [35:4] error_offset, [39:36] zero
  output logic        m_tlast,
  input  logic        cfg_wen,
  input  logic [7:0]  cfg_wdata
);
  import jsv_pkg::*;

  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_DEPTH);

  // Parser state
  logic [7:0]    depth_limit;
  logic [DW-1:0] nest_depth, nest_depth_next;
  logic          top_kind, top_kind_next;
  logic          below_kind;
  logic          comma_flag, comma_flag_next;
  logic          inside_string, inside_string_next;
  logic          escape_pending, escape_pending_next;
  logic [2:0]    hex_left, hex_left_next;
  lit_t          literal_kind, literal_kind_next;
  logic [2:0]    literal_pos, literal_pos_next;
  logic [31:0]   literal_start, literal_start_next;
  logic          inside_number, inside_number_next;
  logic [31:0]   byte_count;
  status_t       sticky_error, sticky_error_next;
  logic [31:0]   sticky_offset, sticky_offset_next;

  // Output register
  status_t       out_status, res_status;
  logic [31:0]   out_offset, res_offset;
  logic          out_last;

  logic          kind_mem [MAX_DEPTH];
  logic          push, pop, push_kind;
  logic [DW-1:0] depth_after;
  logic [DW:0]   rd_sum;
  logic [AW-1:0] rd_addr;
  logic          accept;
  logic [7:0]    c;
  logic [8:0]    lit_step;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = !m_tvalid || m_tready;
  assign c        = s_tdata;
  assign m_tdata  = {4'b0000, out_offset, out_status};
  assign m_tlast  = out_last;

  always_comb begin
    nest_depth_next     = nest_depth;
    top_kind_next       = top_kind;
    comma_flag_next     = comma_flag;
    inside_string_next  = inside_string;
    escape_pending_next = escape_pending;
    hex_left_next       = hex_left;
    literal_kind_next   = literal_kind;
    literal_pos_next    = literal_pos;
    literal_start_next  = literal_start;
    inside_number_next  = inside_number;
    sticky_error_next   = sticky_error;
    sticky_offset_next  = sticky_offset;
    push                = 1'b0;
    pop                 = 1'b0;
    push_kind           = 1'b0;
    lit_step            = {6'd0, literal_pos} + 9'd1;

    if (sticky_error == ST_PENDING) begin
      if (hex_left != 3'd0) begin
        if (is_hex(c)) begin
          hex_left_next = hex_left - 3'd1;
        end else begin
          sticky_error_next  = ST_BAD_UNICODE;
          sticky_offset_next = byte_count;
        end
      end else if (escape_pending) begin
        escape_pending_next = 1'b0;
        if (c == "u") begin
          hex_left_next = 3'd4;
        end else if (!(c inside {"\"", "\\", "/", "b", "f", "n", "r", "t"})) begin
          sticky_error_next  = ST_BAD_ESCAPE;
          sticky_offset_next = byte_count;
        end
      end else if (inside_string) begin
        if (c == "\\") begin
          escape_pending_next = 1'b1;
        end else if (c == "\"") begin
          inside_string_next = 1'b0;
        end else if (c < CTRL_LIMIT) begin
          sticky_error_next  = ST_CTRL_CHAR;
          sticky_offset_next = byte_count;
        end
      end else if (literal_kind != LIT_NONE) begin
        if (literal_pos < 3'd5 && c == lit_char(literal_kind, literal_pos)) begin
          literal_pos_next = lit_step[2:0];
          if (lit_step >= {6'd0, lit_len(literal_kind)}) begin
            literal_kind_next = LIT_NONE;
            literal_pos_next  = 3'd0;
          end
        end else begin
          sticky_error_next  = ST_BAD_LITERAL;
          sticky_offset_next = literal_start;
        end
      end else if (!(inside_number && is_num_char(c))) begin
        // A non-number byte ends the number and is then parsed on its own.
        inside_number_next = 1'b0;
        if (!(c inside {" ", "\t", "\n", 8'h0D, ":"})) begin
          case (c)
            "\"": begin
              inside_string_next = 1'b1;
              comma_flag_next    = 1'b0;
            end
            "{", "[": begin
              if ({1'b0, 8'(nest_depth)} >= {1'b0, depth_limit} ||
                  nest_depth >= DEPTH_MAX) begin
                sticky_error_next  = ST_TOO_DEEP;
                sticky_offset_next = byte_count;
              end else begin
                push            = 1'b1;
                push_kind       = (c == "{");
                top_kind_next   = (c == "{");
                nest_depth_next = nest_depth + 1'b1;
                comma_flag_next = 1'b0;
              end
            end
            "}", "]": begin
              if (nest_depth == '0 || top_kind != (c == "}")) begin
                sticky_error_next  = (c == "}") ? ST_BAD_BRACE : ST_BAD_BRACKET;
                sticky_offset_next = byte_count;
              end else if (comma_flag) begin
                sticky_error_next  = (c == "}") ? ST_COMMA_BRACE : ST_COMMA_BRACKET;
                sticky_offset_next = byte_count;
              end else begin
                pop             = 1'b1;
                top_kind_next   = below_kind;
                nest_depth_next = nest_depth - 1'b1;
                comma_flag_next = 1'b0;
              end
            end
            ",": begin
              // Only the flag of the open level matters; levels below are
              // cleared again when they become the top.
              if (nest_depth != '0) comma_flag_next = 1'b1;
            end
            "t", "f", "n": begin
              literal_kind_next  = (c == "t") ? LIT_TRUE : (c == "f") ? LIT_FALSE : LIT_NULL;
              literal_pos_next   = 3'd1;
              literal_start_next = byte_count;
              comma_flag_next    = 1'b0;
            end
            default: begin
              if (c == "-" || (c >= "0" && c <= "9")) begin
                inside_number_next = 1'b1;
                comma_flag_next    = 1'b0;
              end else begin
                sticky_error_next  = ST_BAD_CHAR;
                sticky_offset_next = byte_count;
              end
            end
          endcase
        end
      end
    end

    // End-of-document checks run on the state left by the last byte.
    if (s_tlast && sticky_error_next == ST_PENDING) begin
      if (literal_kind_next != LIT_NONE) begin
        sticky_error_next  = ST_BAD_LITERAL;
        sticky_offset_next = literal_start_next;
      end else if (inside_string_next) begin
        sticky_error_next  = ST_UNTERM_STR;
        sticky_offset_next = byte_count;
      end else if (nest_depth_next != '0) begin
        sticky_error_next  = ST_UNCLOSED;
        sticky_offset_next = byte_count;
      end
    end

    if (sticky_error_next != ST_PENDING) begin
      res_status = sticky_error_next;
      res_offset = sticky_offset_next;
    end else begin
      res_status = s_tlast ? ST_VALID : ST_PENDING;
      res_offset = 32'd0;
    end
  end

  // The read port always fetches the level below the top that the next cycle
  // will see; without an accepted word the depth does not move.
  assign depth_after = accept ? nest_depth_next : nest_depth;
  assign rd_sum      = {1'b0, depth_after} - (DW + 1)'(2);
  assign rd_addr     = rd_sum[AW-1:0];

  always_ff @(posedge clk) begin
    if (accept && push) begin
      kind_mem[nest_depth[AW-1:0]] <= push_kind;
    end
    below_kind <= kind_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_limit <= DEPTH_LIMIT_RESET;
    end else if (cfg_wen) begin
      depth_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nest_depth     <= '0;
      top_kind       <= 1'b0;
      comma_flag     <= 1'b0;
      inside_string  <= 1'b0;
      escape_pending <= 1'b0;
      hex_left       <= 3'd0;
      literal_kind   <= LIT_NONE;
      literal_pos    <= 3'd0;
      literal_start  <= 32'd0;
      inside_number  <= 1'b0;
      byte_count     <= 32'd0;
      sticky_error   <= ST_PENDING;
      sticky_offset  <= 32'd0;
    end else if (accept) begin
      if (s_tlast) begin
        nest_depth     <= '0;
        top_kind       <= 1'b0;
        comma_flag     <= 1'b0;
        inside_string  <= 1'b0;
        escape_pending <= 1'b0;
        hex_left       <= 3'd0;
        literal_kind   <= LIT_NONE;
        literal_pos    <= 3'd0;
        literal_start  <= 32'd0;
        inside_number  <= 1'b0;
        byte_count     <= 32'd0;
        sticky_error   <= ST_PENDING;
        sticky_offset  <= 32'd0;
      end else begin
        nest_depth     <= nest_depth_next;
        top_kind       <= top_kind_next;
        comma_flag     <= comma_flag_next;
        inside_string  <= inside_string_next;
        escape_pending <= escape_pending_next;
        hex_left       <= hex_left_next;
        literal_kind   <= literal_kind_next;
        literal_pos    <= literal_pos_next;
        literal_start  <= literal_start_next;
        inside_number  <= inside_number_next;
        byte_count     <= byte_count + 32'd1;
        sticky_error   <= sticky_error_next;
        sticky_offset  <= sticky_offset_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= res_status;
      out_offset <= res_offset;
      out_last   <= s_tlast;
    end
  end

  `JSV_ASSERT_NXT(a_last_clears, accept && s_tlast,
    m_tvalid && m_tlast && nest_depth == '0 && byte_count == 32'd0)
  `JSV_ASSERT_NXT(a_error_sticky, accept && !s_tlast && sticky_error != ST_PENDING,
    sticky_error == $past(sticky_error) && out_status == $past(sticky_error))
  `JSV_ASSERT_IMP(a_done_has_verdict, m_tvalid && m_tlast, out_status != ST_PENDING)
  `JSV_ASSERT_NXT(a_push_depth, accept && push && !s_tlast,
    nest_depth == $past(nest_depth) + 1'b1 && top_kind == $past(push_kind))
  `JSV_ASSERT_IMP(a_comma_needs_level, comma_flag, nest_depth != '0)

endmodule
